// ----- sv/sjfs_pkg.sv -----
// Shared types, widths and codes of the shortest-job-first scheduler.
package sjfs_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned ArrW          = 32;
  localparam int unsigned BurstW        = 16;
  localparam int unsigned OrderW        = 32;

  // Request type codes
  localparam logic ReqAdd  = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ArrW-1:0]   arrival_time;
    logic [BurstW-1:0] burst_length;
  } req_t;

  typedef struct packed {
    logic              add_accepted;
    logic              job_started;
    logic              job_ran;
    logic              job_finished;
    logic [ArrW-1:0]   job_arrival;
    logic [BurstW-1:0] job_remaining;
    logic [ArrW-1:0]   now_tick;
  } rsp_t;

  // One job table entry
  typedef struct packed {
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [OrderW-1:0] order;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // latch request, clear index, best and staged word
    logic idx_inc;     // advance slot index
    logic free_write;  // store the job in the slot at the index
    logic pick_read;   // read the slot at the index for comparison
    logic sel_load;    // move the best job to the processor
    logic exec;        // run one tick
    logic out_load;    // move the staged word to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_tick;    // incoming word is a tick request
    logic running;     // a job holds the processor
    logic idx_last;    // index points at the last slot
    logic slot_free;   // slot at the index is empty
  } sts_t;

endpackage

// ----- sv/sjfs_datapath.sv -----
// Datapath of the scheduler: job memory, valid bits, best-job search and tick counters.
module sjfs_datapath #(
  parameter int unsigned TABLE_DEPTH = sjfs_pkg::TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sjfs_pkg::req_t in_req_i,
  input  sjfs_pkg::cmd_t cmd_i,
  output sjfs_pkg::sts_t sts_o,
  output sjfs_pkg::rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  sjfs_pkg::entry_t slot_mem_q [TABLE_DEPTH];
  sjfs_pkg::entry_t rd_q;
  sjfs_pkg::entry_t best_q;
  sjfs_pkg::req_t   req_q;
  sjfs_pkg::rsp_t   res_q;
  sjfs_pkg::rsp_t   out_q;

  logic [TABLE_DEPTH-1:0]      valid_q;
  logic [IdxW-1:0]             idx_q;
  logic [IdxW-1:0]             cmp_idx_q;
  logic                        cmp_vld_q;
  logic [IdxW-1:0]             best_idx_q;
  logic                        best_found_q;
  logic [sjfs_pkg::OrderW-1:0] ins_q;
  logic [sjfs_pkg::ArrW-1:0]   tick_q;
  logic                        running_q;
  logic [sjfs_pkg::ArrW-1:0]   run_arr_q;
  logic [sjfs_pkg::BurstW-1:0] left_q;

  logic eligible;
  logic better;

  // Compare the slot read last cycle against the best so far
  always_comb begin
    eligible = cmp_vld_q && valid_q[cmp_idx_q] && (rd_q.arrival <= tick_q);
    better   = !best_found_q || (rd_q.burst < best_q.burst) ||
               ((rd_q.burst == best_q.burst) && (rd_q.order < best_q.order));
  end

  // Job memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.free_write) begin
      slot_mem_q[idx_q] <= '{arrival: req_q.arrival_time,
                             burst:   req_q.burst_length,
                             order:   ins_q};
    end
    if (cmd_i.pick_read) begin
      rd_q <= slot_mem_q[idx_q];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      idx_q        <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      ins_q        <= '0;
      tick_q       <= '0;
      running_q    <= 1'b0;
      run_arr_q    <= '0;
      left_q       <= '0;
    end else begin
      cmp_vld_q <= cmd_i.pick_read;
      cmp_idx_q <= idx_q;
      if (cmd_i.start) begin
        idx_q        <= '0;
        best_found_q <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (eligible && better) begin
        best_found_q <= 1'b1;
        best_idx_q   <= cmp_idx_q;
      end
      if (cmd_i.free_write) begin
        valid_q[idx_q] <= 1'b1;
        if (ins_q != '1) begin
          ins_q <= ins_q + 1'b1;
        end
      end
      if (cmd_i.sel_load && best_found_q) begin
        valid_q[best_idx_q] <= 1'b0;
        running_q           <= 1'b1;
        run_arr_q           <= best_q.arrival;
        left_q              <= best_q.burst;
      end
      if (cmd_i.exec) begin
        if (running_q) begin
          if (left_q > sjfs_pkg::BurstW'(1)) begin
            left_q <= left_q - 1'b1;
          end else begin
            left_q    <= '0;
            running_q <= 1'b0;
          end
        end
        if (tick_q != '1) begin
          tick_q <= tick_q + 1'b1;
        end
      end
    end
  end

  // Payload: request, best entry, staged and output words
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= in_req_i;
      res_q <= '0;
    end
    if (eligible && better) begin
      best_q <= rd_q;
    end
    if (cmd_i.free_write) begin
      res_q.add_accepted <= 1'b1;
    end
    if (cmd_i.sel_load && best_found_q) begin
      res_q.job_started <= 1'b1;
    end
    if (cmd_i.exec) begin
      res_q.now_tick <= tick_q;
      if (running_q) begin
        res_q.job_ran     <= 1'b1;
        res_q.job_arrival <= run_arr_q;
        if (left_q > sjfs_pkg::BurstW'(1)) begin
          res_q.job_remaining <= left_q - 1'b1;
        end else begin
          res_q.job_remaining <= '0;
          res_q.job_finished  <= 1'b1;
        end
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    sts_o.new_tick  = (in_req_i.req_type == sjfs_pkg::ReqTick);
    sts_o.running   = running_q;
    sts_o.idx_last  = (idx_q == IdxW'(TABLE_DEPTH - 1));
    sts_o.slot_free = !valid_q[idx_q];
  end

  assign out_rsp_o = out_q;

endmodule

// ----- sv/sjfs_ctrl.sv -----
// Controller state machine of the scheduler: sequences scans, execution and output hand-off.
module sjfs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sjfs_pkg::sts_t sts_i,
  output sjfs_pkg::cmd_t cmd_o
);

  localparam logic [2:0] SIdle    = 3'd0;
  localparam logic [2:0] SFree    = 3'd1;
  localparam logic [2:0] SPick    = 3'd2;
  localparam logic [2:0] SPickEnd = 3'd3;
  localparam logic [2:0] SSel     = 3'd4;
  localparam logic [2:0] SExec    = 3'd5;
  localparam logic [2:0] SDone    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (!sts_i.new_tick) begin
            state_d = SFree;
          end else if (sts_i.running) begin
            state_d = SExec;
          end else begin
            state_d = SPick;
          end
        end
      end
      SFree: begin
        if (sts_i.slot_free) begin
          cmd_o.free_write = 1'b1;
          state_d          = SDone;
        end else if (sts_i.idx_last) begin
          state_d = SDone;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      SPick: begin
        cmd_o.pick_read = 1'b1;
        if (sts_i.idx_last) begin
          state_d = SPickEnd;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      SPickEnd: state_d = SSel;   // last comparison lands this cycle
      SSel: begin
        cmd_o.sel_load = 1'b1;
        state_d        = SExec;
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d    = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/shortest_job_first_scheduler_core.sv -----
// Top level of the non-preemptive shortest-job-first scheduler.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o   | sjfs_pkg::req_t (add or tick)
//   out     | output    | out_valid_o/out_ready_i | sjfs_pkg::rsp_t, one per input
//
// Steps: a tick while a job runs goes straight to execution and hand-off; an
// idle-processor tick first has the job memory read port visit every slot, one
// slot a cycle, and runs the best job; an add checks one valid bit a cycle.
// One word is in work at a time; the next is taken once the previous result
// sits in the output register, which holds it until out_ready_i.
// Reset is asynchronous, active low, and empties the table at once: no sweep.
module shortest_job_first_scheduler_core #(
  parameter int unsigned TABLE_DEPTH = sjfs_pkg::TableDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sjfs_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sjfs_pkg::rsp_t out_rsp_o
);

  sjfs_pkg::cmd_t cmd;
  sjfs_pkg::sts_t sts;

  // Sequence each word through scan, pick, execution and hand-off
  sjfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the job table, running job, counters and output word
  sjfs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

`ifndef SYNTHESIS
  // Only one word in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while one is in work");

  // A finished job has run and has nothing left
  a_finish_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.job_finished) |->
      (out_rsp_o.job_ran && (out_rsp_o.job_remaining == '0)))
    else $error("finished job without run or with time left");

  // A picked job runs on the same tick
  a_start_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.job_started) |-> out_rsp_o.job_ran)
    else $error("job started but did not run");

  // An accepted add carries no tick outcome
  a_add_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.add_accepted) |->
      (!out_rsp_o.job_ran && !out_rsp_o.job_started && (out_rsp_o.now_tick == '0)))
    else $error("add result carries tick fields");
`endif

endmodule
